// ===== hdl/parking_distance_indicator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// parking distance indicator assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef PARKING_DISTANCE_INDICATOR_UNIT_ASSERT_SVH
`define PARKING_DISTANCE_INDICATOR_UNIT_ASSERT_SVH

// checked only outside reset
`define PDI_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PDI_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pdi_pkg.sv =====
// ----------------------------------------------------------------------------
// pdi_pkg
// types, codes and constants of the parking distance indicator
// ----------------------------------------------------------------------------
package pdi_pkg;

  localparam int unsigned DEF_MAX_STOP_TENTHS = 60;

  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned MM_W        = 16;
  localparam int unsigned SHOWN_W     = 12;
  localparam int unsigned WIN_W       = 10;
  localparam int unsigned HOLD_W      = 16;
  localparam int unsigned OFS_W       = 6;
  localparam int unsigned INIT_W      = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 24;
  // band, in_edit, awake, save_request, shown_tenths, shown_valid
  localparam int unsigned OUT_FIXED_W = 19;

  localparam logic [WIN_W-1:0]  RST_WINDOW    = WIN_W'(150);
  localparam logic [HOLD_W-1:0] RST_HOLD      = HOLD_W'(10000);
  localparam logic [OFS_W-1:0]  RST_OFFSET    = OFS_W'(20);
  localparam logic [INIT_W-1:0] RST_INIT_STOP = INIT_W'(5);

  // 25*mm against 762*tenths is mm*100 against tenths*3048
  localparam int unsigned MM_X25_W     = 21;
  localparam int unsigned TENTH_X25_MM = 762;
  localparam int unsigned TENTH_X25_W  = 10;
  // (25*mm + 381) / 762 rounds mm to tenths of a foot
  localparam int unsigned HALF_ROUND   = 381;
  localparam int unsigned RECIP_381    = 1409111;
  localparam int unsigned RECIP_W      = 21;
  localparam int unsigned RECIP_SHIFT  = 29;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_MOTION = 3'd1,
    FUNC_UP     = 3'd2,
    FUNC_DOWN   = 3'd3,
    FUNC_SAMPLE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    BAND_STOP  = 3'd0,
    BAND_SLOW  = 3'd1,
    BAND_CLEAR = 3'd2,
    BAND_EDIT  = 3'd3,
    BAND_OFF   = 3'd4
  } band_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW    = 2'd0,
    CFG_HOLD      = 2'd1,
    CFG_OFFSET    = 2'd2,
    CFG_INIT_STOP = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [WIN_W-1:0]  window;
    logic [HOLD_W-1:0] hold;
    logic [OFS_W-1:0]  offset;
    logic [INIT_W-1:0] init_stop;
    logic              stop_load;
  } cfg_t;

  typedef struct packed {
    band_e              band;
    logic [SHOWN_W-1:0] shown;
  } band_res_t;

  typedef struct packed {
    band_e              band;
    logic               in_edit;
    logic               awake;
    logic               save;
    logic [SHOWN_W-1:0] shown;
    logic               shown_ok;
  } res_t;

endpackage

// ===== hdl/pdi_cfg.sv =====
// ----------------------------------------------------------------------------
// pdi_cfg
// configuration registers with zero-as-one handling of window and hold
// ----------------------------------------------------------------------------
module pdi_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pdi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pdi_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output pdi_pkg::cfg_t                    cfg_o
);
  import pdi_pkg::*;

  logic [WIN_W-1:0]  window_q;
  logic [HOLD_W-1:0] hold_q;
  logic [OFS_W-1:0]  offset_q;
  cfg_idx_e          idx;

  assign idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= RST_WINDOW;
      hold_q   <= RST_HOLD;
      offset_q <= RST_OFFSET;
    end else if (cfg_we_i) begin
      case (idx)
        CFG_WINDOW:    window_q <= cfg_data_i[WIN_W-1:0];
        CFG_HOLD:      hold_q   <= cfg_data_i[HOLD_W-1:0];
        CFG_OFFSET:    offset_q <= cfg_data_i[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.window    = (window_q == '0) ? WIN_W'(1) : window_q;
    cfg_o.hold      = (hold_q == '0) ? HOLD_W'(1) : hold_q;
    cfg_o.offset    = offset_q;
    cfg_o.init_stop = cfg_data_i[INIT_W-1:0];
    cfg_o.stop_load = cfg_we_i && (idx == CFG_INIT_STOP);
  end

endmodule

// ===== hdl/pdi_band.sv =====
// ----------------------------------------------------------------------------
// pdi_band
// sample banding against stop and slow thresholds, rounding to tenths
// ----------------------------------------------------------------------------
module pdi_band #(
  parameter int unsigned MAX_STOP_TENTHS = pdi_pkg::DEF_MAX_STOP_TENTHS
) (
  input  logic [$clog2(MAX_STOP_TENTHS+1)-1:0] stop_i,
  input  logic [pdi_pkg::OFS_W-1:0]            offset_i,
  input  logic                                 sample_valid_i,
  input  logic [pdi_pkg::MM_W-1:0]             sample_mm_i,
  output pdi_pkg::band_res_t                   res_o
);
  import pdi_pkg::*;

  localparam int unsigned StopW = $clog2(MAX_STOP_TENTHS + 1);
  localparam int unsigned SumW  = ((StopW > OFS_W) ? StopW : OFS_W) + 1;
  localparam int unsigned NearW = StopW + TENTH_X25_W;
  localparam int unsigned MidW  = SumW + TENTH_X25_W;
  localparam int unsigned CmpW  = (MidW > MM_X25_W) ? MidW : MM_X25_W;
  localparam int unsigned ProdW = (MM_X25_W - 1) + RECIP_W;

  logic [MM_X25_W-1:0] mm25;
  logic [MM_X25_W-1:0] rnd;
  logic [ProdW-1:0]    prod;
  logic [SumW-1:0]     mid_tenths;
  logic [NearW-1:0]    near25;
  logic [MidW-1:0]     mid25;
  logic                above_mid;
  logic                above_near;

  assign mm25 = (MM_X25_W'(sample_mm_i) << 4) + (MM_X25_W'(sample_mm_i) << 3)
              + MM_X25_W'(sample_mm_i);

  assign mid_tenths = SumW'(stop_i) + SumW'(offset_i);
  assign near25     = NearW'(stop_i) * NearW'(TENTH_X25_MM);
  assign mid25      = MidW'(mid_tenths) * MidW'(TENTH_X25_MM);

  assign above_mid  = CmpW'(mm25) > CmpW'(mid25);
  assign above_near = CmpW'(mm25) > CmpW'(near25);

  // halve, then divide by 381 through the reciprocal
  assign rnd  = mm25 + MM_X25_W'(HALF_ROUND);
  assign prod = ProdW'(rnd[MM_X25_W-1:1]) * ProdW'(RECIP_381);

  always_comb begin
    if (!sample_valid_i || above_mid) begin
      res_o.band = BAND_CLEAR;
    end else if (above_near) begin
      res_o.band = BAND_SLOW;
    end else begin
      res_o.band = BAND_STOP;
    end
    res_o.shown = prod[RECIP_SHIFT +: SHOWN_W];
  end

endmodule

// ===== hdl/pdi_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdi_ctrl
// event state: buttons, step timers, edit mode, wake hold and last band
// ----------------------------------------------------------------------------
module pdi_ctrl #(
  parameter int unsigned MAX_STOP_TENTHS = pdi_pkg::DEF_MAX_STOP_TENTHS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pdi_pkg::cfg_t                        cfg_i,
  input  logic                                 ev_en_i,
  input  pdi_pkg::func_e                       func_i,
  input  logic                                 level_i,
  input  logic                                 sample_valid_i,
  input  pdi_pkg::band_res_t                   band_i,
  output logic [$clog2(MAX_STOP_TENTHS+1)-1:0] stop_q_o,
  output logic [$clog2(MAX_STOP_TENTHS+1)-1:0] res_stop_o,
  output pdi_pkg::res_t                        res_o
);
  import pdi_pkg::*;

  localparam int unsigned StopW = $clog2(MAX_STOP_TENTHS + 1);
  localparam int unsigned ClW   = (StopW > INIT_W) ? StopW : INIT_W;
  localparam int unsigned StopRst =
    (RST_INIT_STOP < 1) ? 1 :
    ((RST_INIT_STOP > MAX_STOP_TENTHS) ? MAX_STOP_TENTHS : RST_INIT_STOP);

  logic               edit_q, edit_d;
  logic [StopW-1:0]   stop_q, stop_d;
  logic               up_held_q, up_held_d;
  logic               dn_held_q, dn_held_d;
  logic [WIN_W-1:0]   up_pend_q, up_pend_d;
  logic [WIN_W-1:0]   dn_pend_q, dn_pend_d;
  logic               motion_q, motion_d;
  logic [HOLD_W-1:0]  hold_q, hold_d;
  logic               awake_q, awake_d;
  band_e              last_band_q, last_band_d;
  logic [SHOWN_W-1:0] shown_q, shown_d;
  logic               shown_ok_q, shown_ok_d;
  logic               save;
  logic [StopW-1:0]   stop_t;
  logic [HOLD_W-1:0]  hold_t;
  logic               is_up;
  logic               peer_held;
  logic [ClW-1:0]     init_ext;
  logic [StopW-1:0]   init_clamped;

  assign init_ext = ClW'(cfg_i.init_stop);

  always_comb begin
    if (init_ext == '0) begin
      init_clamped = StopW'(1);
    end else if (init_ext > ClW'(MAX_STOP_TENTHS)) begin
      init_clamped = StopW'(MAX_STOP_TENTHS);
    end else begin
      init_clamped = init_ext[StopW-1:0];
    end
  end

  always_comb begin
    edit_d      = edit_q;
    stop_d      = stop_q;
    up_held_d   = up_held_q;
    dn_held_d   = dn_held_q;
    up_pend_d   = up_pend_q;
    dn_pend_d   = dn_pend_q;
    motion_d    = motion_q;
    hold_d      = hold_q;
    awake_d     = awake_q;
    last_band_d = last_band_q;
    shown_d     = shown_q;
    shown_ok_d  = shown_ok_q;
    save        = 1'b0;
    stop_t      = stop_q;
    hold_t      = hold_q;
    is_up       = (func_i == FUNC_UP);
    peer_held   = is_up ? dn_held_q : up_held_q;

    if (ev_en_i) begin
      case (func_i)
        FUNC_TICK: begin
          // up step first, then down step on the result
          if (up_pend_q != '0) begin
            up_pend_d = up_pend_q - WIN_W'(1);
            if (up_pend_q == WIN_W'(1) && edit_q && stop_t < StopW'(MAX_STOP_TENTHS)) begin
              stop_t = stop_t + StopW'(1);
            end
          end
          if (dn_pend_q != '0) begin
            dn_pend_d = dn_pend_q - WIN_W'(1);
            if (dn_pend_q == WIN_W'(1) && edit_q && stop_t > StopW'(1)) begin
              stop_t = stop_t - StopW'(1);
            end
          end
          stop_d = stop_t;
          if (awake_q) begin
            if (motion_q || edit_q) begin
              hold_d = cfg_i.hold;
            end else begin
              if (hold_q != '0) begin
                hold_t = hold_q - HOLD_W'(1);
              end
              hold_d = hold_t;
              if (hold_t == '0) begin
                awake_d     = 1'b0;
                last_band_d = BAND_OFF;
              end
            end
          end
        end
        FUNC_MOTION: begin
          motion_d = level_i;
          if (level_i) begin
            awake_d = 1'b1;
            hold_d  = cfg_i.hold;
          end
        end
        FUNC_UP, FUNC_DOWN: begin
          if (is_up) begin
            up_held_d = level_i;
          end else begin
            dn_held_d = level_i;
          end
          if (level_i) begin
            if (peer_held) begin
              // chord
              up_pend_d = '0;
              dn_pend_d = '0;
              if (!edit_q) begin
                edit_d  = 1'b1;
                awake_d = 1'b1;
                hold_d  = cfg_i.hold;
              end else begin
                edit_d = 1'b0;
                save   = 1'b1;
              end
            end else if (is_up) begin
              if (up_pend_q == '0) begin
                up_pend_d = cfg_i.window;
              end
            end else begin
              if (dn_pend_q == '0) begin
                dn_pend_d = cfg_i.window;
              end
            end
          end
        end
        FUNC_SAMPLE: begin
          if (awake_q && !edit_q) begin
            last_band_d = band_i.band;
            shown_ok_d  = sample_valid_i;
            if (sample_valid_i) begin
              shown_d = band_i.shown;
            end
          end
        end
        default: ;
      endcase
    end

    if (cfg_i.stop_load) begin
      stop_d = init_clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edit_q      <= 1'b0;
      stop_q      <= StopW'(StopRst);
      up_held_q   <= 1'b0;
      dn_held_q   <= 1'b0;
      up_pend_q   <= '0;
      dn_pend_q   <= '0;
      motion_q    <= 1'b0;
      hold_q      <= '0;
      awake_q     <= 1'b0;
      last_band_q <= BAND_OFF;
      shown_q     <= '0;
      shown_ok_q  <= 1'b0;
    end else begin
      edit_q      <= edit_d;
      stop_q      <= stop_d;
      up_held_q   <= up_held_d;
      dn_held_q   <= dn_held_d;
      up_pend_q   <= up_pend_d;
      dn_pend_q   <= dn_pend_d;
      motion_q    <= motion_d;
      hold_q      <= hold_d;
      awake_q     <= awake_d;
      last_band_q <= last_band_d;
      shown_q     <= shown_d;
      shown_ok_q  <= shown_ok_d;
    end
  end

  always_comb begin
    if (!awake_d) begin
      res_o.band = BAND_OFF;
    end else if (edit_d) begin
      res_o.band = BAND_EDIT;
    end else begin
      res_o.band = last_band_d;
    end
    res_o.in_edit  = edit_d;
    res_o.awake    = awake_d;
    res_o.save     = save;
    res_o.shown    = shown_d;
    res_o.shown_ok = shown_ok_d;
  end

  assign stop_q_o   = stop_q;
  assign res_stop_o = stop_d;

endmodule

// ===== hdl/parking_distance_indicator_unit.sv =====
// ----------------------------------------------------------------------------
// parking_distance_indicator_unit: parking-assist controller, one result per event
// path: input register, then output register; a stalled result holds the input register
// throughput: one transaction per cycle while the result is not stalled, set by the single-pass state update
// reset: asynchronous, clears state and valid flags but not the data registers, stop distance back to 5
// ----------------------------------------------------------------------------
module parking_distance_indicator_unit #(
  parameter int unsigned MAX_STOP_TENTHS = pdi_pkg::DEF_MAX_STOP_TENTHS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // level, sample_valid, sample_mm[15:0]
  input  logic [pdi_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // func[2:0]
  input  logic [pdi_pkg::FUNC_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // band[2:0], stop_tenths, in_edit, awake, save_request, shown_tenths[11:0],
  // shown_valid
  output logic [((pdi_pkg::OUT_FIXED_W + $clog2(MAX_STOP_TENTHS+1) + 7) / 8) * 8 - 1:0]
                                              m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [pdi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pdi_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import pdi_pkg::*;

  localparam int unsigned StopW = $clog2(MAX_STOP_TENTHS + 1);
  localparam int unsigned OutW  = ((OUT_FIXED_W + StopW + 7) / 8) * 8;

  cfg_t             cfg;
  band_res_t        band_res;
  res_t             res;
  logic [StopW-1:0] stop_q;
  logic [StopW-1:0] res_stop;

  logic             in_vld_q, in_vld_d;
  func_e            in_func_q;
  logic             in_level_q;
  logic             in_svalid_q;
  logic [MM_W-1:0]  in_mm_q;
  logic             out_vld_q, out_vld_d;
  logic [OutW-1:0]  out_data_q, out_data_d;
  logic             in_take;
  logic             adv;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = in_take || (in_vld_q && !adv);
  assign out_vld_d     = adv || (out_vld_q && !m_axis_tready);

  pdi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pdi_band #(
    .MAX_STOP_TENTHS (MAX_STOP_TENTHS)
  ) u_band (
    .stop_i         (stop_q),
    .offset_i       (cfg.offset),
    .sample_valid_i (in_svalid_q),
    .sample_mm_i    (in_mm_q),
    .res_o          (band_res)
  );

  pdi_ctrl #(
    .MAX_STOP_TENTHS (MAX_STOP_TENTHS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .ev_en_i        (adv),
    .func_i         (in_func_q),
    .level_i        (in_level_q),
    .sample_valid_i (in_svalid_q),
    .band_i         (band_res),
    .stop_q_o       (stop_q),
    .res_stop_o     (res_stop),
    .res_o          (res)
  );

  assign out_data_d = OutW'({res.shown_ok, res.shown, res.save, res.awake, res.in_edit,
                             res_stop, res.band});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_func_q   <= func_e'(s_axis_tuser);
      in_level_q  <= s_axis_tdata[0];
      in_svalid_q <= s_axis_tdata[1];
      in_mm_q     <= s_axis_tdata[2 +: MM_W];
    end
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/pdi_checker.sv =====
// ----------------------------------------------------------------------------
// pdi_checker
// port-level checks of the parking distance indicator, bound to the top level
// ----------------------------------------------------------------------------
`include "parking_distance_indicator_unit_assert.svh"

module pdi_checker #(
  parameter int unsigned MAX_STOP_TENTHS = pdi_pkg::DEF_MAX_STOP_TENTHS
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((pdi_pkg::OUT_FIXED_W + $clog2(MAX_STOP_TENTHS+1) + 7) / 8) * 8 - 1:0]
                                             m_axis_tdata
);
  import pdi_pkg::*;

  localparam int unsigned StopW    = $clog2(MAX_STOP_TENTHS + 1);
  localparam int unsigned EditBit  = 3 + StopW;
  localparam int unsigned AwakeBit = EditBit + 1;
  localparam int unsigned SaveBit  = EditBit + 2;

  band_e out_band;
  logic  out_edit;
  logic  out_awake;
  logic  out_save;

  assign out_band  = band_e'(m_axis_tdata[2:0]);
  assign out_edit  = m_axis_tdata[EditBit];
  assign out_awake = m_axis_tdata[AwakeBit];
  assign out_save  = m_axis_tdata[SaveBit];

  `PDI_ASSERT_ALWAYS(a_rst_no_result, clk_i, !rst_ni |=> !m_axis_tvalid,
    "result valid during reset")

  `PDI_ASSERT(a_result_held, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "stalled result changed")

  `PDI_ASSERT(a_stall_cause, clk_i, rst_ni,
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready,
    "input stalled without a blocked result")

  `PDI_ASSERT(a_band_mode, clk_i, rst_ni,
    m_axis_tvalid |-> (out_awake || out_band == BAND_OFF) &&
                      (!out_awake || !out_edit || out_band == BAND_EDIT),
    "band does not match awake and edit state")

  `PDI_ASSERT(a_save_on_leave, clk_i, rst_ni,
    m_axis_tvalid && out_save |-> !out_edit && out_awake,
    "save request outside leaving edit mode")

endmodule

bind parking_distance_indicator_unit pdi_checker #(
  .MAX_STOP_TENTHS (MAX_STOP_TENTHS)
) u_pdi_checker (.*);
